// ----- hdl/interrupt_priority_controller_core_macros.svh -----
// ----------------------------------------------------------------------------
// Interrupt priority controller assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_PRIORITY_CONTROLLER_CORE_MACROS_SVH
`define INTERRUPT_PRIORITY_CONTROLLER_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define IPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// Interrupt priority controller package
// Shared commands, register indexes, vector bases and cell interface types.
// ----------------------------------------------------------------------------
package ipc_pkg;

  typedef enum logic [1:0] {
    CMD_SET_LINE  = 2'd0,
    CMD_POST_EXC  = 2'd1,
    CMD_POST_TRAP = 2'd2,
    CMD_EVALUATE  = 2'd3
  } ipc_cmd_e;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PORT_IRQ_EN = 3'd0,
    REG_PRIORITY_A  = 3'd1,
    REG_PRIORITY_B  = 3'd2,
    REG_PRIORITY_C  = 3'd3,
    REG_PRIORITY_D  = 3'd4
  } ipc_reg_e;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [5:0] VEC_EXC_BASE = 6'd15;
  localparam logic [5:0] VEC_SRC_BASE = 6'd19;
  localparam logic [2:0] NMI_LEVEL    = 3'd7;
  localparam int unsigned TRACE_BIT   = 15;
  localparam int unsigned MASK_LSB    = 8;
  localparam int unsigned IRQ0_EN_BIT = 5;
  localparam int unsigned IRQ1_EN_BIT = 6;

  typedef struct packed {
    logic [7:0] port_irq_enable;
    logic [7:0] priority_a;
    logic [7:0] priority_b;
    logic [7:0] priority_c;
    logic [7:0] priority_d;
  } ipc_cfg_t;

  // Per-cell control from the top level.
  typedef struct packed {
    logic set_line;
    logic clr_line;
    logic eval;
    logic qualify;
    logic clear_on_hit;
  } ipc_cell_ctrl_t;

  // Priority level of a line; zero for gated-off or unassigned lines.
  function automatic logic [2:0] line_level(input logic [4:0] idx, input ipc_cfg_t cfg);
    logic [2:0] lvl;
    lvl = 3'd0;
    unique case (idx)
      5'd0: lvl = NMI_LEVEL;
      5'd1: lvl = cfg.port_irq_enable[IRQ0_EN_BIT] ? cfg.priority_a[6:4] : 3'd0;
      5'd2: lvl = cfg.port_irq_enable[IRQ1_EN_BIT] ? cfg.priority_a[2:0] : 3'd0;
      5'd3, 5'd4, 5'd5:    lvl = cfg.priority_b[6:4];
      5'd6, 5'd7, 5'd8:    lvl = cfg.priority_b[2:0];
      5'd9, 5'd10, 5'd11:  lvl = cfg.priority_c[6:4];
      5'd12, 5'd13, 5'd14: lvl = cfg.priority_c[2:0];
      5'd15:               lvl = cfg.priority_d[2:0];
      5'd16, 5'd17:        lvl = cfg.priority_d[6:4];
      default:             lvl = 3'd0;
    endcase
    return lvl;
  endfunction

endpackage

// ----- hdl/ipc_cell.sv -----
// ----------------------------------------------------------------------------
// Interrupt priority controller cell
// One pending bit with a grant link in the priority chain.
// ----------------------------------------------------------------------------
module ipc_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ipc_pkg::ipc_cell_ctrl_t ctrl_i,
  input  logic                    blocked_i,
  output logic                    blocked_o,
  output logic                    hit_o
);
  import ipc_pkg::*;

  logic pend_q, pend_d;
  logic active;

  assign active    = pend_q & ctrl_i.qualify & ctrl_i.eval;
  assign hit_o     = active & ~blocked_i;
  assign blocked_o = blocked_i | active;

  always_comb begin
    pend_d = pend_q;
    if (ctrl_i.set_line) begin
      pend_d = 1'b1;
    end else if (ctrl_i.clr_line || (hit_o && ctrl_i.clear_on_hit)) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

// ----- hdl/interrupt_priority_controller_core.sv -----
// The result for an accepted input word is registered and shows on m_tdata in the next cycle.
// Throughput: one word per cycle; the output register lets a new word in
// whenever the result register is empty or being drained in the same cycle.
// Grant selection ripples through two rows of cells (traps, then request lines).
// Reset clears all pending traps, the waiting exception, request lines and
// configuration registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Interrupt priority controller core
// Trap, exception, NMI and source arbitration against the status mask.
// ----------------------------------------------------------------------------
module interrupt_priority_controller_core #(
  parameter int unsigned TRAP_COUNT   = 16,
  parameter int unsigned SOURCE_COUNT = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ipc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [ipc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input word
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // source[4:0], request[5], exception_code[7:6], trap_number[11:8],
  // status_word[27:12], zero fill [31:28]
  input  logic [ipc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // command[1:0]
  input  logic [ipc_pkg::IN_TUSER_W-1:0]      s_tuser,
  // result word
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // taken[0], vector_code[6:1], saved_status[22:7], new_status[38:23],
  // wake[39]
  output logic [ipc_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import ipc_pkg::*;

  // Unpack the input word.
  ipc_cmd_e    cmd;
  logic [4:0]  in_source;
  logic        in_request;
  logic [1:0]  in_exc;
  logic [3:0]  in_trap;
  logic [15:0] in_status;
  logic [2:0]  cur_mask;
  logic        accept;
  logic        do_eval;

  assign cmd        = ipc_cmd_e'(s_tuser);
  assign in_source  = s_tdata[4:0];
  assign in_request = s_tdata[5];
  assign in_exc     = s_tdata[7:6];
  assign in_trap    = s_tdata[11:8];
  assign in_status  = s_tdata[27:12];
  assign cur_mask   = in_status[MASK_LSB+:3];
  assign accept     = s_tvalid & s_tready;
  assign do_eval    = accept && (cmd == CMD_EVALUATE);

  // Configuration registers: write-only, unknown indexes are dropped.
  ipc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PORT_IRQ_EN: cfg_q.port_irq_enable <= cfg_wdata_i;
        REG_PRIORITY_A:  cfg_q.priority_a      <= cfg_wdata_i;
        REG_PRIORITY_B:  cfg_q.priority_b      <= cfg_wdata_i;
        REG_PRIORITY_C:  cfg_q.priority_c      <= cfg_wdata_i;
        REG_PRIORITY_D:  cfg_q.priority_d      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Trap row: lowest pending trap wins and is cleared on grant.
  logic [TRAP_COUNT:0]   trap_blk;
  logic [TRAP_COUNT-1:0] trap_hit;
  logic                  trap_any;

  assign trap_blk[0] = 1'b0;
  assign trap_any    = trap_blk[TRAP_COUNT];

  for (genvar t = 0; t < TRAP_COUNT; t++) begin : g_trap
    ipc_cell_ctrl_t ctrl;
    always_comb begin
      ctrl.set_line     = accept && (cmd == CMD_POST_TRAP) && (in_trap == 4'(t));
      ctrl.clr_line     = 1'b0;
      ctrl.eval         = do_eval;
      ctrl.qualify      = 1'b1;
      ctrl.clear_on_hit = 1'b1;
    end
    ipc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .blocked_i (trap_blk[t]),
      .blocked_o (trap_blk[t+1]),
      .hit_o     (trap_hit[t])
    );
  end

  // Waiting exception: replaced on post, consumed when it wins. Code zero
  // means none, so posting zero drops a waiting one.
  logic [1:0] exc_q, exc_d;
  logic       exc_hit;

  assign exc_hit = do_eval && !trap_any && (exc_q != 2'd0);

  always_comb begin
    exc_d = exc_q;
    if (accept && (cmd == CMD_POST_EXC)) begin
      exc_d = in_exc;
    end else if (exc_hit) begin
      exc_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exc_q <= 2'd0;
    end else begin
      exc_q <= exc_d;
    end
  end

  // Request-line row: line 0 is NMI (always qualifies at level 7), the
  // rest qualify when their level is above the current mask. Lines stay
  // level sensitive and are never cleared by a grant.
  logic [SOURCE_COUNT:0]   src_blk;
  logic [SOURCE_COUNT-1:0] src_hit;
  logic [2:0]              src_lvl [SOURCE_COUNT];

  assign src_blk[0] = trap_any | exc_hit;

  for (genvar s = 0; s < SOURCE_COUNT; s++) begin : g_src
    ipc_cell_ctrl_t ctrl;
    logic           line_sel;
    assign src_lvl[s] = line_level(5'(s), cfg_q);
    assign line_sel   = accept && (cmd == CMD_SET_LINE) && (in_source == 5'(s));
    always_comb begin
      ctrl.set_line     = line_sel & in_request;
      ctrl.clr_line     = line_sel & ~in_request;
      ctrl.eval         = do_eval;
      ctrl.qualify      = (s == 0) ? 1'b1 : (cur_mask < src_lvl[s]);
      ctrl.clear_on_hit = 1'b0;
    end
    ipc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .blocked_i (src_blk[s]),
      .blocked_o (src_blk[s+1]),
      .hit_o     (src_hit[s])
    );
  end

  // Build the result from the one-hot grants.
  logic        src_any;
  logic        taken;
  logic [5:0]  vec_code;
  logic [2:0]  new_mask;
  logic [15:0] new_status;
  logic [OUT_TDATA_W-1:0] result;

  assign src_any = |src_hit;
  assign taken   = trap_any | exc_hit | src_any;

  always_comb begin
    vec_code = 6'd0;
    new_mask = 3'd0;
    for (int unsigned i = 0; i < TRAP_COUNT; i++) begin
      if (trap_hit[i]) vec_code |= 6'(i);
    end
    if (exc_hit) vec_code |= VEC_EXC_BASE + 6'(exc_q);
    for (int unsigned i = 0; i < SOURCE_COUNT; i++) begin
      if (src_hit[i]) begin
        vec_code |= VEC_SRC_BASE + 6'(i);
        new_mask |= src_lvl[i];
      end
    end
  end

  always_comb begin
    new_status            = in_status;
    new_status[TRACE_BIT] = 1'b0;
    if (src_any) new_status[MASK_LSB+:3] = new_mask;
  end

  assign result = taken ? {1'b1, new_status, in_status, vec_code, 1'b1} : '0;

  // Output register: refill while draining.
  logic                   out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  assign s_tready = ~out_vld_q | m_tready;
  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (m_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) out_data_q <= result;
  end

endmodule

// ----- hdl/ipc_checker.sv -----
// ----------------------------------------------------------------------------
// Interrupt priority controller checker
// Port-level checks on result words and output timing.
// ----------------------------------------------------------------------------
`include "interrupt_priority_controller_core_macros.svh"

module ipc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ipc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ipc_pkg::*;

  logic        taken;
  logic        wake;
  logic [15:0] saved_sw;
  logic [15:0] new_sw;
  logic        status_ok;

  assign taken    = m_tdata[0];
  assign saved_sw = m_tdata[22:7];
  assign new_sw   = m_tdata[38:23];
  assign wake     = m_tdata[39];

  // trace dropped, status bits outside the mask kept
  assign status_ok = !new_sw[TRACE_BIT] && (new_sw[14:11] == saved_sw[14:11]) &&
                     (new_sw[7:0] == saved_sw[7:0]);

  // wake always follows taken
  `IPC_ASSERT_NOW(a_wake_eq_taken, m_tvalid, wake == taken, "wake differs from taken")

  // a word without a vector is all zero
  `IPC_ASSERT_NOW(a_idle_zero, m_tvalid && !taken, m_tdata[39:1] == '0, "untaken word not zero")

  `IPC_ASSERT_NOW(a_status_keep, m_tvalid && taken, status_ok, "new status corrupts fields")

  // every accepted word shows a result next cycle
  `IPC_ASSERT_NEXT(a_one_cycle, s_tvalid && s_tready, m_tvalid, "result missing after accept")

  // stalled result holds
  `IPC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind interrupt_priority_controller_core ipc_checker u_ipc_checker (.*);

// ----- test/tb_interrupt_priority_controller_core.sv -----
// ----------------------------------------------------------------------------
// Interrupt priority controller core testbench
// Drives command words into the stream input and predicts each result word
// from a behavioral model of the trap, exception, NMI and source arbitration.
// Results are checked field by field in arrival order. Configuration changes
// happen only while no word is in flight. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_interrupt_priority_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;

  localparam int TRAPS     = 16;
  localparam int SOURCES   = 18;
  localparam int LONG_HOLD = 48;    // receiver hold-off for the backpressure test
  localparam int LIMIT     = 1000;  // cycles without any handshake before giving up

  // Register indexes past the last mapped register; writes there are dropped.
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

  // Input word layout, lowest bit last.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] status_word;
    logic [3:0]  trap_num;
    logic [1:0]  exc_code;
    logic        request;
    logic [4:0]  source;
  } request_word_t;

  // Result word layout, lowest bit last.
  typedef struct packed {
    logic        wake;
    logic [15:0] new_sw;
    logic [15:0] saved_sw;
    logic [5:0]  vec;
    logic        taken;
  } grant_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic [IN_TUSER_W-1:0] s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Model state: pending traps, waiting exception, request line levels.
  logic [TRAPS-1:0]   trap_pend = '0;
  logic [1:0]         exc_wait  = '0;
  logic [SOURCES-1:0] line_req  = '0;
  // Model copy of the configuration registers.
  logic [7:0] irq_en_reg = '0;
  logic [7:0] pri_a_reg  = '0;
  logic [7:0] pri_b_reg  = '0;
  logic [7:0] pri_c_reg  = '0;
  logic [7:0] pri_d_reg  = '0;

  grant_t pending_grants[$];

  int error_count   = 0;
  int words_in      = 0;
  int results_seen  = 0;
  int trap_vectors  = 0;
  int exc_vectors   = 0;
  int nmi_vectors   = 0;
  int src_vectors   = 0;
  int no_vector     = 0;
  int quiet_cycles  = 0;

  bit send_gaps    = 1'b1;
  bit ready_gaps   = 1'b1;
  bit hold_request = 1'b0;

  interrupt_priority_controller_core #(
    .TRAP_COUNT  (TRAPS),
    .SOURCE_COUNT(SOURCES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------

  // Priority level of request line n under the current configuration copy.
  function automatic logic [2:0] source_level(input int n);
    logic [2:0] lvl;
    lvl = 3'd0;
    if (n == 1) begin
      if (irq_en_reg[IRQ0_EN_BIT]) lvl = pri_a_reg[6:4];
    end else if (n == 2) begin
      if (irq_en_reg[IRQ1_EN_BIT]) lvl = pri_a_reg[2:0];
    end else if (n >= 3 && n <= 5) begin
      lvl = pri_b_reg[6:4];
    end else if (n >= 6 && n <= 8) begin
      lvl = pri_b_reg[2:0];
    end else if (n >= 9 && n <= 11) begin
      lvl = pri_c_reg[6:4];
    end else if (n >= 12 && n <= 14) begin
      lvl = pri_c_reg[2:0];
    end else if (n == 15) begin
      lvl = pri_d_reg[2:0];
    end else if (n == 16 || n == 17) begin
      lvl = pri_d_reg[6:4];
    end
    return lvl;
  endfunction

  // Apply one command word to the model state and return the grant it yields.
  function automatic grant_t predict_grant(input ipc_cmd_e cmd, input request_word_t w);
    grant_t      g;
    logic [2:0]  mask_lvl;
    logic [2:0]  lvl;
    logic [15:0] nsw;
    g = '0;
    unique case (cmd)
      CMD_SET_LINE: begin
        // Lines past the last source are dropped.
        if (w.source < SOURCES) line_req[w.source] = w.request;
      end
      CMD_POST_EXC: begin
        // Code zero clears; any other code replaces what is waiting.
        exc_wait = w.exc_code;
      end
      CMD_POST_TRAP: begin
        if (w.trap_num < TRAPS) trap_pend[w.trap_num] = 1'b1;
      end
      CMD_EVALUATE: begin
        mask_lvl = w.status_word[MASK_LSB +: 3];
        nsw = w.status_word;
        nsw[TRACE_BIT] = 1'b0;
        // Lowest pending trap wins and is consumed.
        for (int i = 0; i < TRAPS && !g.taken; i++) begin
          if (trap_pend[i]) begin
            trap_pend[i] = 1'b0;
            g.taken = 1'b1;
            g.vec = 6'(i);
          end
        end
        if (!g.taken && exc_wait != 2'd0) begin
          g.vec = VEC_EXC_BASE + 6'(exc_wait);
          exc_wait = 2'd0;
          g.taken = 1'b1;
        end
        // NMI is level sensitive and stays requested.
        if (!g.taken && line_req[0]) begin
          g.vec = VEC_SRC_BASE;
          nsw[MASK_LSB +: 3] = NMI_LEVEL;
          g.taken = 1'b1;
        end
        for (int i = 1; i < SOURCES && !g.taken; i++) begin
          lvl = source_level(i);
          if (line_req[i] && mask_lvl < lvl) begin
            g.vec = VEC_SRC_BASE + 6'(i);
            nsw[MASK_LSB +: 3] = lvl;
            g.taken = 1'b1;
          end
        end
        if (g.taken) begin
          g.saved_sw = w.status_word;
          g.new_sw = nsw;
          g.wake = 1'b1;
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake tracking: predict on input words, check on result words
  // --------------------------------------------------------------------------

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  always @(posedge clk_i) begin : track_words
    grant_t got_g;
    grant_t want_g;
    if (rst_ni) begin
      // Predict first so a same-edge result always finds its expectation.
      if (s_tvalid && s_tready) begin
        pending_grants.push_back(predict_grant(ipc_cmd_e'(s_tuser), request_word_t'(s_tdata)));
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        got_g = grant_t'(m_tdata);
        results_seen++;
        if (pending_grants.size() == 0) begin
          error_count++;
          $display("%0t: result word 0x%0h arrived with nothing expected", $time, m_tdata);
        end else begin
          want_g = pending_grants.pop_front();
          report_field("taken", want_g.taken, got_g.taken);
          report_field("vector_code", want_g.vec, got_g.vec);
          report_field("saved_status", want_g.saved_sw, got_g.saved_sw);
          report_field("new_status", want_g.new_sw, got_g.new_sw);
          report_field("wake", want_g.wake, got_g.wake);
          if (!want_g.taken) no_vector++;
          else if (want_g.vec < VEC_EXC_BASE + 6'd1) trap_vectors++;
          else if (want_g.vec < VEC_SRC_BASE) exc_vectors++;
          else if (want_g.vec == VEC_SRC_BASE) nmi_vectors++;
          else src_vectors++;
        end
      end
    end
  end

  // Abort when no word moves on either side for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, LIMIT, pending_grants.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off when requested.
  initial begin : drive_ready
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD - 1;
        m_tready <= 1'b0;
      end else if (ready_gaps && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // --------------------------------------------------------------------------

  // Offer one word and hold it until the block takes it. Valid stays high on
  // return so back-to-back words never drop it.
  task automatic send_word(input ipc_cmd_e cmd, input request_word_t w);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= w;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Write one register and mirror it in the model. Leaves the enable high.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    unique case (addr)
      REG_PORT_IRQ_EN: irq_en_reg = data;
      REG_PRIORITY_A:  pri_a_reg = data;
      REG_PRIORITY_B:  pri_b_reg = data;
      REG_PRIORITY_C:  pri_c_reg = data;
      REG_PRIORITY_D:  pri_d_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Write all registers plus one unmapped index, which must change nothing.
  task automatic apply_settings(input logic [7:0] en, input logic [7:0] pa,
                                input logic [7:0] pb, input logic [7:0] pc,
                                input logic [7:0] pd);
    cfg_write(REG_PORT_IRQ_EN, en);
    cfg_write(REG_PRIORITY_A, pa);
    cfg_write(REG_UNMAPPED_LO + 3'($urandom_range(0, REG_UNMAPPED_HI - REG_UNMAPPED_LO)),
              8'($urandom));
    cfg_write(REG_PRIORITY_B, pb);
    cfg_write(REG_PRIORITY_C, pc);
    cfg_write(REG_PRIORITY_D, pd);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic request_word_t make_word(input logic [4:0] src, input logic req,
                                              input logic [1:0] exc, input logic [3:0] trap,
                                              input logic [15:0] sw);
    request_word_t w;
    w = '0;
    w.source = src;
    w.request = req;
    w.exc_code = exc;
    w.trap_num = trap;
    w.status_word = sw;
    return w;
  endfunction

  // Mostly line updates and evaluations; traps are kept rarer than
  // evaluations so sources still get a chance to win.
  function automatic ipc_cmd_e pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return CMD_SET_LINE;
    if (r < 50) return CMD_POST_EXC;
    if (r < 58) return CMD_POST_TRAP;
    return CMD_EVALUATE;
  endfunction

  // Every field but the pad random; fields a command leaves unused still toggle all their bits.
  function automatic request_word_t random_word();
    request_word_t w;
    int unsigned r;
    w = '0;
    w.status_word = 16'($urandom);
    w.trap_num = 4'($urandom);
    w.exc_code = 2'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      // NMI masks every source while high, so set it rarely.
      w.source = 5'd0;
      w.request = ($urandom_range(0, 3) == 0);
    end else begin
      w.source = (r < 90) ? 5'($urandom_range(1, SOURCES - 1))
                          : 5'($urandom_range(SOURCES, 31));
      w.request = 1'($urandom);
    end
    return w;
  endfunction

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_word(pick_command(), random_word());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every command, the field extremes and each corner of the arbitration.
  task automatic test_directed();
    apply_settings(8'h60, 8'h53, 8'h21, 8'h64, 8'h17);
    // nothing pending: all-zero result
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0000));
    send_word(CMD_POST_TRAP, make_word(5'd0, 1'b0, 2'd0, 4'd15, 16'h0000));
    send_word(CMD_POST_TRAP, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0000));
    // newer exception replaces the waiting one
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd3, 4'd0, 16'h0000));
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd1, 4'd0, 16'h0000));
    send_word(CMD_SET_LINE, make_word(5'd0, 1'b1, 2'd0, 4'd0, 16'h0000));
    send_word(CMD_SET_LINE, make_word(5'd17, 1'b1, 2'd0, 4'd0, 16'h0000));
    // lines past the last source are ignored
    send_word(CMD_SET_LINE, make_word(5'd31, 1'b1, 2'd0, 4'd0, 16'h0000));
    send_word(CMD_SET_LINE, make_word(5'd18, 1'b1, 2'd0, 4'd0, 16'h0000));
    // traps first, lowest number first, then the exception
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'hFFFF));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h8000));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h1234));
    // code zero clears a waiting exception
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd2, 4'd0, 16'h0000));
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0000));
    // NMI ignores the mask
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h8700));
    send_word(CMD_SET_LINE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0000));
    // serial source above and then at the mask
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0000));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0100));
    // IRQ0 above the mask wins while the serial source is masked
    send_word(CMD_SET_LINE, make_word(5'd1, 1'b1, 2'd0, 4'd0, 16'h0000));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h0400));
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd3, 4'd0, 16'h0000));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'hC0DE));
    send_word(CMD_POST_EXC, make_word(5'd0, 1'b0, 2'd2, 4'd0, 16'h0000));
    send_word(CMD_EVALUATE, make_word(5'd0, 1'b0, 2'd0, 4'd0, 16'h7FFF));
    wait_results_drained();
  endtask

  // Receiver holds off long while the sender keeps offering words.
  task automatic test_backpressure();
    apply_settings(8'hFF, 8'h76, 8'h54, 8'h32, 8'h71);
    send_gaps = 1'b0;
    hold_request = 1'b1;
    send_random(40);
    send_gaps = 1'b1;
    wait_results_drained();
  endtask

  // Sender pauses mid-stream until the block has fully drained.
  task automatic test_drain_pause();
    send_random(20);
    wait_results_drained();
    send_random(20);
    wait_results_drained();
  endtask

  // Random phases over several settings; the last one runs with no idling.
  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      wait_results_drained();
      if (p == 0) begin
        apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      end else if (p == 1) begin
        apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      end else begin
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      send_gaps = (p != 7);
      ready_gaps = (p != 7);
      send_random(90);
    end
    wait_results_drained();
  endtask

  initial begin : run_tests
    int waited;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_SET_LINE;
    cfg_we_i = 1'b0;
    cfg_addr_i = REG_PORT_IRQ_EN;
    cfg_wdata_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random();

    // Let stragglers arrive, bounded, then settle a few more cycles.
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_grants.size() != 0 && waited < 200) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (4) @(negedge clk_i);
    if (pending_grants.size() != 0) begin
      error_count += pending_grants.size();
      $display("%0t: %0d expected results never arrived", $time, pending_grants.size());
    end

    $display("Covered %0d command words and %0d result words over 10 register settings.",
             words_in, results_seen);
    $display("Vectors: %0d trap, %0d exception, %0d NMI, %0d source; %0d with no vector.",
             trap_vectors, exc_vectors, nmi_vectors, src_vectors, no_vector);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ipc_pkg.sv
hdl/ipc_cell.sv
hdl/interrupt_priority_controller_core.sv
hdl/ipc_checker.sv
test/tb_interrupt_priority_controller_core.sv
